/* rtl/core/bsn_pkg.sv */
`timescale 1ns / 1ps

package bsn_pkg;

  // Defaults for the top-level parameters
  localparam int MaxCandidates = 64;
  localparam int WordWidth     = 16;

  // Fixed field widths
  localparam int ClassW  = 8;
  localparam int CoordW  = 16;  // output coordinate / score width, IoU working width
  localparam int PosW    = 9;   // word position within a box, up to 3 + 255
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_NUM_CLASSES       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCORE_THRESHOLD   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OVERLAP_THRESHOLD = 2'd2;

  // Configuration reset values
  localparam logic [ClassW-1:0] NumClassesRst       = 8'd80;
  localparam logic [CfgW-1:0]   ScoreThresholdRst   = 16'd16384;
  localparam logic [CfgW-1:0]   OverlapThresholdRst = 16'd29491;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INS_BEGIN,
    OP_INS_TOP,
    OP_INS_PROBE,
    OP_INS_MOVE,
    OP_SUP_BEGIN,
    OP_SUP_RDI,
    OP_SUP_LATI,
    OP_SUP_RDJ,
    OP_SUP_WAIT,
    OP_SUP_TEST,
    OP_EMIT_BEGIN,
    OP_EMIT_RD,
    OP_EMIT_CHK,
    OP_EMIT_NONE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic acc;   // input beat taken this cycle
  } cmd_t;

  typedef struct packed {
    logic box_ins;    // accepted word closes a box that goes into the store
    logic box_set;    // accepted word closes the set
    logic set_pend;   // set closed, suppression due after insertion
    logic full;
    logic k_zero;
    logic rd_ge;      // read entry score >= new box score
    logic rd_flag;    // read entry is suppressed
    logic i_end;
    logic j_end;
    logic kept_zero;
    logic emit_done;
    logic out_free;
  } sta_t;

endpackage

/* rtl/core/box_select_nms.sv */
`timescale 1ns / 1ps
// Greedy non-maximum suppression over a stream of detector boxes.
// Input channel (in_valid_i / in_stall_o): one word a beat. A box is four
// coordinate words (cx, cy, w, h; Q12.4) then num_classes score words
// (Q0.16). last_of_box_i marks a box's final word, last_of_set_i the set's.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 num_classes, 1 score
// threshold, 2 overlap threshold; always ready, write only while idle.
// Output channel (out_valid_o / out_stall_i): one beat per kept box in score
// order, last_result_o on the final one; an empty set gives a single beat
// with none_found_o set.
// Rate: words load at one a cycle while the input is not stalled. A box that
// clears the score threshold stalls input while it is inserted, longer for each
// entry it displaces (single-port sorted store). After the set, suppression
// compares pairs (read, IoU multiply pipeline, test) and visits each stored box,
// then emission reads each stored box.
// A stalled result holds in the output register; emission waits for it.
// Reset: store empty, config at defaults, no result pending.
module box_select_nms #(
  parameter int MAX_CANDIDATES = bsn_pkg::MaxCandidates,
  parameter int WORD_WIDTH     = bsn_pkg::WordWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [WORD_WIDTH-1:0]        word_value_i,
  input  logic                         last_of_box_i,
  input  logic                         last_of_set_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bsn_pkg::CoordW-1:0]   center_x_o,
  output logic [bsn_pkg::CoordW-1:0]   center_y_o,
  output logic [bsn_pkg::CoordW-1:0]   box_width_o,
  output logic [bsn_pkg::CoordW-1:0]   box_height_o,
  output logic [bsn_pkg::CoordW-1:0]   best_score_o,
  output logic [bsn_pkg::ClassW-1:0]   class_index_o,
  output logic                         none_found_o,
  output logic                         last_result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bsn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bsn_pkg::CfgW-1:0]     cfg_data_i
);
  import bsn_pkg::*;

  logic [ClassW-1:0] num_classes_q;
  logic [CfgW-1:0]   score_thr_q;
  logic [CfgW-1:0]   overlap_thr_q;
  cmd_t              cmd;
  sta_t              sta;

  assign cfg_ready_o = 1'b1;

  // config registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= NumClassesRst;
      score_thr_q   <= ScoreThresholdRst;
      overlap_thr_q <= OverlapThresholdRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_NUM_CLASSES) num_classes_q <= cfg_data_i[ClassW-1:0];
      if (cfg_index_i == CFG_SCORE_THRESHOLD) score_thr_q <= cfg_data_i;
      if (cfg_index_i == CFG_OVERLAP_THRESHOLD) overlap_thr_q <= cfg_data_i;
    end
  end

  bsn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sta_i      (sta),
    .cmd_o      (cmd)
  );

  bsn_datapath #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .WORD_WIDTH     (WORD_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sta_o               (sta),
    .word_value_i        (word_value_i),
    .last_of_box_i       (last_of_box_i),
    .last_of_set_i       (last_of_set_i),
    .num_classes_i       (num_classes_q),
    .score_threshold_i   (score_thr_q),
    .overlap_threshold_i (overlap_thr_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .center_x_o          (center_x_o),
    .center_y_o          (center_y_o),
    .box_width_o         (box_width_o),
    .box_height_o        (box_height_o),
    .best_score_o        (best_score_o),
    .class_index_o       (class_index_o),
    .none_found_o        (none_found_o),
    .last_result_o       (last_result_o)
  );

endmodule

/* rtl/core/bsn_ctrl.sv */
`timescale 1ns / 1ps

module bsn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsn_pkg::sta_t sta_i,
  output bsn_pkg::cmd_t cmd_o
);
  import bsn_pkg::*;

  typedef enum logic [15:0] {
    S_LOAD       = 16'h0001,
    S_INS_BEGIN  = 16'h0002,
    S_INS_TOP    = 16'h0004,
    S_INS_PROBE  = 16'h0008,
    S_INS_MOVE   = 16'h0010,
    S_SUP_BEGIN  = 16'h0020,
    S_SUP_RDI    = 16'h0040,
    S_SUP_LATI   = 16'h0080,
    S_SUP_RDJ    = 16'h0100,
    S_SUP_WAIT   = 16'h0200,
    S_SUP_TEST   = 16'h0400,
    S_EMIT_BEGIN = 16'h0800,
    S_EMIT_RD    = 16'h1000,
    S_EMIT_CHK   = 16'h2000,
    S_EMIT_NONE  = 16'h4000,
    S_CLEAR      = 16'h8000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] wait_q, wait_d;
  state_e     after_ins;
  logic       acc;

  assign in_stall_o = (state_q != S_LOAD);
  assign acc        = in_valid_i && (state_q == S_LOAD);
  assign after_ins  = sta_i.set_pend ? S_SUP_BEGIN : S_LOAD;

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    cmd_o.acc = acc;
    cmd_o.op  = OP_LOAD;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        if (acc) begin
          if (sta_i.box_ins) state_d = S_INS_BEGIN;
          else if (sta_i.box_set) state_d = S_SUP_BEGIN;
        end
      end
      S_INS_BEGIN: begin
        cmd_o.op = OP_INS_BEGIN;
        state_d  = sta_i.full ? S_INS_TOP : S_INS_PROBE;
      end
      S_INS_TOP: begin
        cmd_o.op = OP_INS_TOP;
        state_d  = sta_i.rd_ge ? after_ins : S_INS_PROBE;
      end
      S_INS_PROBE: begin
        cmd_o.op = OP_INS_PROBE;
        state_d  = sta_i.k_zero ? after_ins : S_INS_MOVE;
      end
      S_INS_MOVE: begin
        cmd_o.op = OP_INS_MOVE;
        state_d  = sta_i.rd_ge ? after_ins : S_INS_PROBE;
      end
      S_SUP_BEGIN: begin
        cmd_o.op = OP_SUP_BEGIN;
        state_d  = S_SUP_RDI;
      end
      S_SUP_RDI: begin
        cmd_o.op = OP_SUP_RDI;
        state_d  = sta_i.i_end ? S_EMIT_BEGIN : S_SUP_LATI;
      end
      S_SUP_LATI: begin
        cmd_o.op = OP_SUP_LATI;
        state_d  = sta_i.rd_flag ? S_SUP_RDI : S_SUP_RDJ;
      end
      S_SUP_RDJ: begin
        cmd_o.op = OP_SUP_RDJ;
        wait_d   = '0;
        state_d  = sta_i.j_end ? S_SUP_RDI : S_SUP_WAIT;
      end
      S_SUP_WAIT: begin
        cmd_o.op = OP_SUP_WAIT;
        wait_d   = wait_q + 2'd1;
        if (wait_q == 2'd3) state_d = S_SUP_TEST;
      end
      S_SUP_TEST: begin
        cmd_o.op = OP_SUP_TEST;
        state_d  = S_SUP_RDJ;
      end
      S_EMIT_BEGIN: begin
        cmd_o.op = OP_EMIT_BEGIN;
        state_d  = sta_i.kept_zero ? S_EMIT_NONE : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd_o.op = OP_EMIT_RD;
        state_d  = sta_i.emit_done ? S_CLEAR : S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        cmd_o.op = OP_EMIT_CHK;
        if (sta_i.rd_flag || sta_i.out_free) state_d = S_EMIT_RD;
      end
      S_EMIT_NONE: begin
        cmd_o.op = OP_EMIT_NONE;
        if (sta_i.out_free) state_d = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        state_d  = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

endmodule

/* rtl/core/bsn_datapath.sv */
`timescale 1ns / 1ps

module bsn_datapath #(
  parameter int MAX_CANDIDATES = bsn_pkg::MaxCandidates,
  parameter int WORD_WIDTH     = bsn_pkg::WordWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bsn_pkg::cmd_t                   cmd_i,
  output bsn_pkg::sta_t                   sta_o,
  input  logic [WORD_WIDTH-1:0]           word_value_i,
  input  logic                            last_of_box_i,
  input  logic                            last_of_set_i,
  input  logic [bsn_pkg::ClassW-1:0]      num_classes_i,
  input  logic [bsn_pkg::CfgW-1:0]        score_threshold_i,
  input  logic [bsn_pkg::CfgW-1:0]        overlap_threshold_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bsn_pkg::CoordW-1:0]      center_x_o,
  output logic [bsn_pkg::CoordW-1:0]      center_y_o,
  output logic [bsn_pkg::CoordW-1:0]      box_width_o,
  output logic [bsn_pkg::CoordW-1:0]      box_height_o,
  output logic [bsn_pkg::CoordW-1:0]      best_score_o,
  output logic [bsn_pkg::ClassW-1:0]      class_index_o,
  output logic                            none_found_o,
  output logic                            last_result_o
);
  import bsn_pkg::*;

  localparam int WW  = WORD_WIDTH;
  localparam int AW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW  = $clog2(MAX_CANDIDATES + 1);
  localparam int MW  = (WW > CfgW) ? WW : CfgW;
  localparam int GS  = (WW > CoordW) ? WW - CoordW : 0;
  // entry layout: {flag, class, score, h, w, y, x}
  localparam int GeoW = 4 * WW;
  localparam int ScO  = GeoW;
  localparam int ClO  = GeoW + WW;
  localparam int FlO  = GeoW + WW + ClassW;
  localparam int EW   = FlO + 1;
  localparam logic [CW-1:0] MaxC = CW'(MAX_CANDIDATES);

  function automatic logic [17:0] span(input logic [CoordW-1:0] c1, input logic [CoordW-1:0] e1,
                                       input logic [CoordW-1:0] c2, input logic [CoordW-1:0] e2);
    logic signed [19:0] lo1, hi1, lo2, hi2, lo, hi;
    lo1 = $signed({3'b0, c1, 1'b0}) - $signed({4'b0, e1});
    hi1 = $signed({3'b0, c1, 1'b0}) + $signed({4'b0, e1});
    lo2 = $signed({3'b0, c2, 1'b0}) - $signed({4'b0, e2});
    hi2 = $signed({3'b0, c2, 1'b0}) + $signed({4'b0, e2});
    lo  = (lo1 > lo2) ? lo1 : lo2;
    hi  = (hi1 < hi2) ? hi1 : hi2;
    return (hi > lo) ? 18'(hi - lo) : 18'd0;
  endfunction

  function automatic logic [CoordW-1:0] g16(input logic [WW-1:0] v);
    return CoordW'(v >> GS);
  endfunction

  // box tracking
  logic [PosW-1:0]   pos_q;
  logic [WW-1:0]     geo_q [4];
  logic [WW-1:0]     max_q;
  logic [ClassW-1:0] cls_q;
  logic [WW-1:0]     w_geo [4];
  logic [WW-1:0]     w_max;
  logic [ClassW-1:0] w_cls;
  logic [ClassW-1:0] ncls;
  logic              box_end, box_ins;
  logic              set_pend_q;
  logic [EW-1:0]     new_q;

  // store
  logic [EW-1:0]     mem [MAX_CANDIDATES];
  logic [EW-1:0]     rdata_q, wdata;
  logic              re, we;
  logic [AW-1:0]     raddr, waddr;
  logic [CW-1:0]     count_q, count_inc;
  logic [AW-1:0]     k_q;
  logic [CW-1:0]     i_q, j_q, kept_q, emit_q;

  // overlap pipeline
  logic [CoordW-1:0] a_q [4];
  logic [CoordW-1:0] b [4];
  logic [17:0]       ox_q, oy_q;
  logic [CoordW-1:0] wa_q, ha_q, wb_q, hb_q;
  logic [35:0]       inter2_q, inter3_q, inter4_q;
  logic [31:0]       aa_q, ab_q;
  logic [35:0]       uni_q;
  logic [51:0]       rhs_q;
  logic              hit;
  logic              rd_flag;

  // output register
  logic              push, push_none, push_last;

  always_comb begin
    ncls = (num_classes_i == '0) ? ClassW'(1) : num_classes_i;
    for (int n = 0; n < 4; n++) w_geo[n] = geo_q[n];
    w_max = max_q;
    w_cls = cls_q;
    if (pos_q < PosW'(4)) begin
      w_geo[pos_q[1:0]] = word_value_i;
    end else if (pos_q == PosW'(4) || word_value_i > max_q) begin
      w_max = word_value_i;
      w_cls = ClassW'(pos_q - PosW'(4));
    end
    box_end = last_of_box_i || last_of_set_i || (pos_q >= PosW'(3) + PosW'(ncls));
    box_ins = box_end && (pos_q >= PosW'(4)) && (MW'(w_max) > MW'(score_threshold_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      max_q      <= '0;
      cls_q      <= '0;
      set_pend_q <= 1'b0;
      for (int n = 0; n < 4; n++) geo_q[n] <= '0;
    end else if (cmd_i.op == OP_LOAD && cmd_i.acc) begin
      for (int n = 0; n < 4; n++) geo_q[n] <= w_geo[n];
      if (box_end) begin
        pos_q      <= '0;
        max_q      <= '0;
        cls_q      <= '0;
        set_pend_q <= last_of_set_i;
      end else begin
        pos_q <= pos_q + PosW'(1);
        max_q <= w_max;
        cls_q <= w_cls;
      end
    end else if (cmd_i.op == OP_CLEAR) begin
      set_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && cmd_i.acc && box_end) begin
      new_q <= {1'b0, w_cls, w_max, w_geo[3], w_geo[2], w_geo[1], w_geo[0]};
    end
  end

  assign rd_flag   = rdata_q[FlO];
  assign count_inc = (count_q == MaxC) ? count_q : count_q + CW'(1);

  // memory port control
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = new_q;
    unique case (cmd_i.op)
      OP_INS_BEGIN: begin
        re    = (count_q == MaxC);
        raddr = AW'(MAX_CANDIDATES - 1);
      end
      OP_INS_PROBE: begin
        if (k_q == '0) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = k_q - AW'(1);
        end
      end
      OP_INS_MOVE: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = sta_o.rd_ge ? new_q : rdata_q;
      end
      OP_SUP_RDI, OP_EMIT_RD: begin
        re    = 1'b1;
        raddr = i_q[AW-1:0];
      end
      OP_SUP_RDJ: begin
        re    = !sta_o.j_end;
        raddr = j_q[AW-1:0];
      end
      OP_SUP_TEST: begin
        we    = !rd_flag && hit;
        waddr = j_q[AW-1:0];
        wdata = rdata_q | (EW'(1) << FlO);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      kept_q  <= '0;
      emit_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_INS_BEGIN: k_q <= (count_q == MaxC) ? AW'(MAX_CANDIDATES - 1) : count_q[AW-1:0];
        OP_INS_PROBE: if (k_q == '0) count_q <= count_inc;
        OP_INS_MOVE: begin
          if (sta_o.rd_ge) count_q <= count_inc;
          else k_q <= k_q - AW'(1);
        end
        OP_SUP_BEGIN: begin
          i_q    <= '0;
          kept_q <= '0;
        end
        OP_SUP_LATI: begin
          if (rd_flag) begin
            i_q <= i_q + CW'(1);
          end else begin
            kept_q <= kept_q + CW'(1);
            j_q    <= i_q + CW'(1);
          end
        end
        OP_SUP_RDJ: if (sta_o.j_end) i_q <= i_q + CW'(1);
        OP_SUP_TEST: j_q <= j_q + CW'(1);
        OP_EMIT_BEGIN: begin
          i_q    <= '0;
          emit_q <= '0;
        end
        OP_EMIT_CHK: begin
          if (rd_flag) begin
            i_q <= i_q + CW'(1);
          end else if (sta_o.out_free) begin
            i_q    <= i_q + CW'(1);
            emit_q <= emit_q + CW'(1);
          end
        end
        OP_CLEAR: count_q <= '0;
        default: begin
        end
      endcase
    end
  end

  // kept box of the outer loop and overlap pipeline
  always_comb begin
    for (int n = 0; n < 4; n++) b[n] = g16(rdata_q[n*WW +: WW]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SUP_LATI) begin
      for (int n = 0; n < 4; n++) a_q[n] <= b[n];
    end
    ox_q     <= span(a_q[0], a_q[2], b[0], b[2]);
    oy_q     <= span(a_q[1], a_q[3], b[1], b[3]);
    wa_q     <= a_q[2];
    ha_q     <= a_q[3];
    wb_q     <= b[2];
    hb_q     <= b[3];
    inter2_q <= 36'(ox_q) * 36'(oy_q);
    aa_q     <= 32'(wa_q) * 32'(ha_q);
    ab_q     <= 32'(wb_q) * 32'(hb_q);
    inter3_q <= inter2_q;
    uni_q    <= 36'({aa_q, 2'b00}) + 36'({ab_q, 2'b00}) - inter2_q;
    inter4_q <= inter3_q;
    rhs_q    <= 52'(overlap_threshold_i) * 52'(uni_q);
  end

  assign hit = {inter4_q, 16'b0} > rhs_q;

  // result register
  assign push      = (cmd_i.op == OP_EMIT_CHK) && !rd_flag && sta_o.out_free;
  assign push_none = (cmd_i.op == OP_EMIT_NONE) && sta_o.out_free;
  assign push_last = (emit_q + CW'(1)) == kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (push || push_none) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      center_x_o    <= CoordW'(rdata_q[0*WW +: WW]);
      center_y_o    <= CoordW'(rdata_q[1*WW +: WW]);
      box_width_o   <= CoordW'(rdata_q[2*WW +: WW]);
      box_height_o  <= CoordW'(rdata_q[3*WW +: WW]);
      best_score_o  <= CoordW'(rdata_q[ScO +: WW]);
      class_index_o <= rdata_q[ClO +: ClassW];
      none_found_o  <= 1'b0;
      last_result_o <= push_last;
    end else if (push_none) begin
      center_x_o    <= '0;
      center_y_o    <= '0;
      box_width_o   <= '0;
      box_height_o  <= '0;
      best_score_o  <= '0;
      class_index_o <= '0;
      none_found_o  <= 1'b1;
      last_result_o <= 1'b0;
    end
  end

  // status
  always_comb begin
    sta_o.box_ins   = box_ins;
    sta_o.box_set   = last_of_set_i;
    sta_o.set_pend  = set_pend_q;
    sta_o.full      = (count_q == MaxC);
    sta_o.k_zero    = (k_q == '0);
    sta_o.rd_ge     = rdata_q[ScO +: WW] >= new_q[ScO +: WW];
    sta_o.rd_flag   = rd_flag;
    sta_o.i_end     = (i_q == count_q);
    sta_o.j_end     = (j_q == count_q);
    sta_o.kept_zero = (kept_q == '0);
    sta_o.emit_done = (emit_q == kept_q);
    sta_o.out_free  = !out_valid_o || !out_stall_i;
  end

endmodule
